FILE: design/ctp_pkg.sv
package ctp_pkg;

    // Datapath widths
    localparam int CORDIC_W  = 32;   // rotator x and y
    localparam int ANGLE_W   = 26;   // rotator angle accumulator
    localparam int K_W       = 5;    // iteration index
    localparam int STEPS     = 18;   // rotator iterations
    localparam int PRESCALE  = 12;   // sample scaling before rotation
    localparam int SAMPLE_W  = 16;
    localparam int DEMOD_W   = 17;
    localparam int TURN_W    = 24;   // phase, frequency, error, gains
    localparam int LIMIT_W   = 23;
    localparam int MUL_HI_W  = 26;   // upper part of the serial product register
    localparam int PROD_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [16:0] INV_GAIN  = 17'd39797;
    localparam int          DEMOD_MAX = 46341;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_FREQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LIMIT   = 3'd3;

    typedef struct packed {
        logic           load;
        logic           step;
        logic           vec_mode;
        logic [K_W-1:0] k;
    } t_cordic_ctl;

    // atan(2^-k) in 2^-24 turn
    function automatic logic signed [ANGLE_W-1:0] turn_atan(input logic [K_W-1:0] k);
        logic signed [ANGLE_W-1:0] v;
        case (k)
            5'd0:    v = 26'sd2097152;
            5'd1:    v = 26'sd1238021;
            5'd2:    v = 26'sd654136;
            5'd3:    v = 26'sd332050;
            5'd4:    v = 26'sd166669;
            5'd5:    v = 26'sd83416;
            5'd6:    v = 26'sd41718;
            5'd7:    v = 26'sd20860;
            5'd8:    v = 26'sd10430;
            5'd9:    v = 26'sd5215;
            5'd10:   v = 26'sd2608;
            5'd11:   v = 26'sd1304;
            5'd12:   v = 26'sd652;
            5'd13:   v = 26'sd326;
            5'd14:   v = 26'sd163;
            5'd15:   v = 26'sd81;
            5'd16:   v = 26'sd41;
            5'd17:   v = 26'sd20;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/ctp_cordic.sv
module ctp_cordic (
    input  logic                                  i_clk,
    input  ctp_pkg::t_cordic_ctl                  i_ctl,
    input  logic signed [ctp_pkg::CORDIC_W-1:0]   i_x,
    input  logic signed [ctp_pkg::CORDIC_W-1:0]   i_y,
    input  logic signed [ctp_pkg::ANGLE_W-1:0]    i_z,
    output logic signed [ctp_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [ctp_pkg::CORDIC_W-1:0]   o_y,
    output logic signed [ctp_pkg::ANGLE_W-1:0]    o_z
);
    import ctp_pkg::*;

    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ANGLE_W-1:0]  r_z;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  atan_k;
    logic                       pos;

    // One micro-rotation; rotation mode steers by angle, vectoring by y
    always_comb begin
        dx     = r_y >>> i_ctl.k;
        dy     = r_x >>> i_ctl.k;
        atan_k = turn_atan(i_ctl.k);
        pos    = i_ctl.vec_mode ? !(r_y > 0) : !r_z[ANGLE_W-1];
    end

    // Load a vector or advance one iteration
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (i_ctl.step) begin
            if (pos) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_k;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_k;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: design/ctp_smul.sv
module ctp_smul (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic                                 i_step,
    input  logic signed [ctp_pkg::TURN_W-1:0]    i_mcand,
    input  logic        [ctp_pkg::TURN_W-1:0]    i_mplier,
    output logic signed [ctp_pkg::PROD_W-1:0]    o_prod
);
    import ctp_pkg::*;

    logic signed [TURN_W-1:0]          r_mcand;
    logic signed [MUL_HI_W-1:0]        r_hi;
    logic        [TURN_W-1:0]          r_lo;
    logic signed [MUL_HI_W-1:0]        sum;
    logic signed [MUL_HI_W+TURN_W-1:0] shifted;

    // Add the multiplicand on a set multiplier bit, then shift right
    always_comb begin
        sum     = r_hi + (r_lo[0] ? MUL_HI_W'(r_mcand) : '0);
        shifted = $signed({sum, r_lo}) >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (i_step) begin
            r_hi <= shifted[MUL_HI_W+TURN_W-1:TURN_W];
            r_lo <= shifted[TURN_W-1:0];
        end
    end

    assign o_prod = $signed({r_hi[PROD_W-TURN_W-1:0], r_lo});

endmodule

FILE: design/carrier_tracking_pll.sv
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// sample   | i_in_valid, o_in_ready, i_i_in, i_q_in         | in
// demod    | o_out_valid, i_out_ready, o_demod_out          | out
// config   | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// From acceptance to result, one sample passes through 18 rotation
// iterations and 18 vectoring iterations on the shared CORDIC, then 24
// bit-serial steps of the two gain multipliers, plus load/update cycles.
// A new sample is taken only when the loop is idle; the result sits in an
// output register, so a stalled consumer delays at most the following
// sample's completion. Reset is synchronous; config writes are always
// accepted.
module carrier_tracking_pll (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [ctp_pkg::SAMPLE_W-1:0]    i_i_in,
    input  logic signed [ctp_pkg::SAMPLE_W-1:0]    i_q_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [ctp_pkg::DEMOD_W-1:0]     o_demod_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [ctp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [ctp_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import ctp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_DEM  = 3'd2;
    localparam logic [2:0] S_ATN  = 3'd3;
    localparam logic [2:0] S_MLD  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [K_W-1:0] LAST_STEP = K_W'(STEPS - 1);
    localparam logic [K_W-1:0] LAST_MUL  = K_W'(TURN_W - 1);

    logic [2:0]                r_state, n_state;
    logic [K_W-1:0]            r_cnt, n_cnt;
    logic [TURN_W-1:0]         r_phase_gain, r_freq_gain;
    logic [LIMIT_W-1:0]        r_freq_limit;
    logic [TURN_W-1:0]         r_phase;
    logic signed [TURN_W-1:0]  r_freq;
    logic                      r_zero;
    logic signed [DEMOD_W-1:0] r_demod, r_out_data;
    logic                      r_out_valid;

    t_cordic_ctl               cctl;
    logic signed [CORDIC_W-1:0] ld_x, ld_y, c_x, c_y;
    logic signed [ANGLE_W-1:0]  ld_z, c_z;

    logic                      in_acc, cfg_acc, out_free;
    logic [TURN_W-1:0]         z_neg;
    logic [TURN_W:0]           z_bias;
    logic [2:0]                quad;
    logic signed [CORDIC_W-1:0] sx, sy;

    logic signed [CORDIC_W+17:0] dem_prod;
    logic signed [20:0]          dem_rnd;
    logic signed [DEMOD_W-1:0]   dem_sat;

    logic signed [TURN_W-1:0]  err;
    logic                      mul_load, mul_step;
    logic signed [PROD_W-1:0]  fprod, pprod;
    logic signed [PROD_W+1:0]  frnd_full, prnd_full;
    logic signed [26:0]        nf, lim;
    logic signed [TURN_W-1:0]  nf_clamped;
    logic signed [26:0]        delta;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Rotator load: coarse quarter-turn of the sample, or fold in S_DEM
    always_comb begin
        z_neg  = TURN_W'(0) - r_phase;
        z_bias = {1'b0, z_neg} + (TURN_W+1)'(24'h200000);
        quad   = z_bias[TURN_W:22];
        sx     = CORDIC_W'(i_i_in) <<< PRESCALE;
        sy     = CORDIC_W'(i_q_in) <<< PRESCALE;
        case (quad[1:0])
            2'd0:    begin ld_x = sx;  ld_y = sy;  end
            2'd1:    begin ld_x = -sy; ld_y = sx;  end
            2'd2:    begin ld_x = -sx; ld_y = -sy; end
            default: begin ld_x = sy;  ld_y = -sx; end
        endcase
        ld_z = $signed({2'b00, z_neg}) - $signed({1'b0, quad, 22'd0});
        if (r_state == S_DEM) begin
            if (c_x < 0) begin
                ld_x = -c_x;
                ld_y = -c_y;
                ld_z = ANGLE_W'(24'h800000);
            end else begin
                ld_x = c_x;
                ld_y = c_y;
                ld_z = '0;
            end
        end
    end

    // Gain removal and saturation of the demodulated sample
    always_comb begin
        dem_prod = c_x * $signed({1'b0, INV_GAIN});
        dem_rnd  = 21'((dem_prod + (CORDIC_W+18)'(1 <<< 27)) >>> 28);
        if (dem_rnd > 21'sd46341)
            dem_sat = DEMOD_W'(DEMOD_MAX);
        else if (dem_rnd < -21'sd46341)
            dem_sat = -DEMOD_W'(DEMOD_MAX);
        else
            dem_sat = dem_rnd[DEMOD_W-1:0];
    end

    // Shared rotator control
    always_comb begin
        cctl.load     = in_acc || (r_state == S_DEM);
        cctl.step     = (r_state == S_ROT) || (r_state == S_ATN);
        cctl.vec_mode = (r_state == S_ATN);
        cctl.k        = r_cnt;
    end

    ctp_cordic u_cordic (
        .i_clk (i_clk),
        .i_ctl (cctl),
        .i_x   (ld_x),
        .i_y   (ld_y),
        .i_z   (ld_z),
        .o_x   (c_x),
        .o_y   (c_y),
        .o_z   (c_z)
    );

    assign err      = r_zero ? '0 : $signed(c_z[TURN_W-1:0]);
    assign mul_load = (r_state == S_MLD);
    assign mul_step = (r_state == S_MUL);

    ctp_smul u_freq_mul (
        .i_clk    (i_clk),
        .i_load   (mul_load),
        .i_step   (mul_step),
        .i_mcand  (err),
        .i_mplier (r_freq_gain),
        .o_prod   (fprod)
    );

    ctp_smul u_phase_mul (
        .i_clk    (i_clk),
        .i_load   (mul_load),
        .i_step   (mul_step),
        .i_mcand  (err),
        .i_mplier (r_phase_gain),
        .o_prod   (pprod)
    );

    // Loop filter: round products, clamp frequency, advance phase
    always_comb begin
        frnd_full  = ((PROD_W+2)'(fprod) + $signed((PROD_W+2)'(24'h800000))) >>> 24;
        prnd_full  = ((PROD_W+2)'(pprod) + $signed((PROD_W+2)'(24'h800000))) >>> 24;
        nf         = 27'(r_freq) + frnd_full[26:0];
        lim        = $signed({4'd0, r_freq_limit});
        if (nf > lim)
            nf_clamped = lim[TURN_W-1:0];
        else if (nf < -lim)
            nf_clamped = TURN_W'(-lim);
        else
            nf_clamped = nf[TURN_W-1:0];
        delta      = prnd_full[26:0] + 27'(nf_clamped);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (in_acc) n_state = S_ROT;
            end
            S_ROT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_DEM;
                    n_cnt   = '0;
                end
            end
            S_DEM: begin
                n_state = S_ATN;
                n_cnt   = '0;
            end
            S_ATN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_MLD;
                    n_cnt   = '0;
                end
            end
            S_MLD: begin
                n_state = S_MUL;
                n_cnt   = '0;
            end
            S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_MUL) n_state = S_UPD;
            end
            S_UPD: n_state = S_OUT;
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_phase_gain <= '0;
            r_freq_gain  <= '0;
            r_freq_limit <= {LIMIT_W{1'b1}};
            r_phase      <= '0;
            r_freq       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_UPD) begin
                r_freq  <= nf_clamped;
                r_phase <= r_phase + delta[TURN_W-1:0];
            end
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_PHASE_GAIN:   r_phase_gain <= i_cfg_data;
                    REG_FREQ_GAIN:    r_freq_gain  <= i_cfg_data;
                    REG_NOMINAL_FREQ: r_freq       <= {1'b0, i_cfg_data[LIMIT_W-1:0]};
                    REG_FREQ_LIMIT:   r_freq_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DEM) begin
            r_demod <= dem_sat;
            r_zero  <= (c_x == 0) && (c_y == 0);
        end
        if (r_state == S_OUT && out_free)
            r_out_data <= r_demod;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_demod_out = r_out_data;

endmodule

FILE: design/ctp_checker.sv
module ctp_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [ctp_pkg::DEMOD_W-1:0]   o_demod_out
);
    import ctp_pkg::*;

    // One sample at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sample taken while busy");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_demod_out)))
        else $error("stalled result dropped or changed");

    // Result stays inside the saturation range
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_demod_out <= DEMOD_W'(DEMOD_MAX) &&
                         o_demod_out >= -DEMOD_W'(DEMOD_MAX)))
        else $error("result out of range");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind carrier_tracking_pll ctp_checker u_ctp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_demod_out (o_demod_out)
);
